// File: design/aesp_pkg.sv
// Shared types and constants for the escape sequence parser.
package aesp_pkg;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_STEP,
        SQ_FINAL,
        SQ_COLOR,
        SQ_EMIT
    } seq_state_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_BDC,
        PH_CSI
    } parse_phase_t;

    typedef enum logic [2:0] {
        ACT_REJECT    = 3'd0,
        ACT_UPDATE    = 3'd1,
        ACT_ERASE     = 3'd2,
        ACT_REPEAT    = 3'd3,
        ACT_DRAW_MODE = 3'd4
    } action_t;

    typedef enum logic [1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1,
        REG_DEF_FG  = 2'd2,
        REG_DEF_BG  = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        action_t     action;
        logic [7:0]  new_row;
        logic [7:0]  new_col;
        logic [7:0]  erase_x0;
        logic [7:0]  erase_y0;
        logic [7:0]  erase_x1;
        logic [7:0]  erase_y1;
        logic [15:0] repeat_count;
        logic [7:0]  repeat_byte;
    } result_t;

    localparam logic [7:0] COLUMNS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET    = 8'd25;
    localparam logic [3:0] FG_RESET      = 4'd7;
    localparam logic [3:0] BG_RESET      = 4'd0;

    localparam logic [7:0] CH_ESC      = 8'h1B;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_QUEST    = 8'h3F;
    localparam logic [7:0] CH_UP       = 8'h41;
    localparam logic [7:0] CH_DOWN     = 8'h42;
    localparam logic [7:0] CH_RIGHT    = 8'h43;
    localparam logic [7:0] CH_AT       = 8'h40;
    localparam logic [7:0] CH_LEFT     = 8'h44;
    localparam logic [7:0] CH_SGR      = 8'h6D;
    localparam logic [7:0] CH_RESET    = 8'h6C;
    localparam logic [7:0] CH_ERASE_DS = 8'h4A;
    localparam logic [7:0] CH_ERASE_LN = 8'h4B;
    localparam logic [7:0] CH_ERASE_CH = 8'h58;
    localparam logic [7:0] CH_POS      = 8'h48;
    localparam logic [7:0] CH_ROW_ABS  = 8'h64;
    localparam logic [7:0] CH_COL_ABS  = 8'h47;
    localparam logic [7:0] CH_REPEAT   = 8'h62;

    localparam int unsigned SGR_FG_LO = 30;
    localparam int unsigned SGR_BG_LO = 40;
    localparam int unsigned SGR_BG_HI = 50;

endpackage

// File: design/ansi_escape_sequence_parser.sv
// Top level of the ANSI escape sequence parser with its sequencer and argument store.
//
// Input requests arrive on the s_axis channel, one terminal byte each, packed with the
// current cursor and the last printed character. A request that finishes or breaks a
// sequence produces one result on the m_axis channel; other bytes produce none.
// Configuration (screen size, default colors) is written through the APB port by the
// user only while idle; the block itself does not enforce this.
// States: a byte that gives no result passes only the step state. A byte that gives a
// result directly (after ESC or in the drawing mode selection) then passes the emit
// state; the final byte of a CSI sequence passes the final state before it, and an 'm'
// byte with stored arguments also the color state, where one compare unit classifies
// them one per cycle. s_axis_tready is high only while the sequencer waits for a request.
//
// Results sit in an output register. A new request is accepted while a result waits; if
// the receiver stalls, the next result is held in the sequencer until the output register
// is free, and no further request is taken meanwhile.
//
// Reset clears the parse state, restores the colors and screen size to their defaults
// and clears drawing mode. The argument store needs no clearing.
module ansi_escape_sequence_parser #(
    parameter int MAX_ARGS = 10,
    parameter int ARG_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // data_byte[7:0], cursor_row[15:8], cursor_col[23:16], previous_char[31:24]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // new_row[7:0], new_col[15:8], fg_out[19:16], bg_out[23:20], block_drawing[24],
    // erase_x0[32:25], erase_y0[40:33], erase_x1[48:41], erase_y1[56:49],
    // repeat_count[72:57], repeat_byte[80:73], zero fill[87:81]
    output logic [87:0] m_axis_tdata,
    // action[2:0]
    output logic [2:0]  m_axis_tuser
);

    localparam int IDX_W = (MAX_ARGS > 1) ? $clog2(MAX_ARGS) : 1;
    localparam int CNT_W = $clog2(MAX_ARGS + 1);
    localparam logic [ARG_BITS-1:0] ARG_SAT = '1;

    // Configuration registers.
    logic [7:0] cols_reg;
    logic [7:0] rows_reg;
    logic [3:0] def_fg_reg;
    logic [3:0] def_bg_reg;
    logic       cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg   <= aesp_pkg::COLUMNS_RESET;
            rows_reg   <= aesp_pkg::ROWS_RESET;
            def_fg_reg <= aesp_pkg::FG_RESET;
            def_bg_reg <= aesp_pkg::BG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (aesp_pkg::cfg_reg_t'(paddr[3:2]))
                aesp_pkg::REG_COLUMNS: cols_reg   <= pwdata[7:0];
                aesp_pkg::REG_ROWS:    rows_reg   <= pwdata[7:0];
                aesp_pkg::REG_DEF_FG:  def_fg_reg <= pwdata[3:0];
                aesp_pkg::REG_DEF_BG:  def_bg_reg <= pwdata[3:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (aesp_pkg::cfg_reg_t'(paddr[3:2]))
            aesp_pkg::REG_COLUMNS: prdata = {24'd0, cols_reg};
            aesp_pkg::REG_ROWS:    prdata = {24'd0, rows_reg};
            aesp_pkg::REG_DEF_FG:  prdata = {28'd0, def_fg_reg};
            aesp_pkg::REG_DEF_BG:  prdata = {28'd0, def_bg_reg};
        endcase
    end

    logic [7:0] cols_eff;
    logic [7:0] rows_eff;
    logic [7:0] max_col;
    logic [7:0] max_row;

    assign cols_eff = (cols_reg == 8'd0) ? 8'd1 : cols_reg;
    assign rows_eff = (rows_reg == 8'd0) ? 8'd1 : rows_reg;
    assign max_col  = cols_eff - 8'd1;
    assign max_row  = rows_eff - 8'd1;

    // Sequencer and parse state.
    aesp_pkg::seq_state_t   seq_reg, seq_next;
    aesp_pkg::parse_phase_t phase_reg, phase_next;
    logic [CNT_W-1:0]       arg_total_reg, arg_total_next;
    logic                   pending_reg, pending_next;
    logic [ARG_BITS-1:0]    acc_reg, acc_next;
    logic [CNT_W-1:0]       walk_reg, walk_next;
    logic [3:0]             fg_reg, fg_next;
    logic [3:0]             bg_reg, bg_next;
    logic                   draw_reg, draw_next;
    aesp_pkg::result_t      res_reg, res_next;
    logic                   commit_en;

    // Request held for processing.
    logic [7:0] byte_reg;
    logic [7:0] crow_reg;
    logic [7:0] ccol_reg;
    logic [7:0] prev_reg;
    logic       in_accept;

    assign s_axis_tready = (seq_reg == aesp_pkg::SQ_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            byte_reg <= s_axis_tdata[7:0];
            crow_reg <= (s_axis_tdata[15:8] > max_row) ? max_row : s_axis_tdata[15:8];
            ccol_reg <= (s_axis_tdata[23:16] > max_col) ? max_col : s_axis_tdata[23:16];
            prev_reg <= s_axis_tdata[31:24];
        end
    end

    // Argument store.
    logic [ARG_BITS-1:0] arg_mem_reg [MAX_ARGS];
    logic [ARG_BITS-1:0] arg0;
    logic [ARG_BITS-1:0] arg1;
    logic [ARG_BITS-1:0] walk_arg;

    always_ff @(posedge clk)
    begin
        if (commit_en)
        begin
            arg_mem_reg[arg_total_reg[IDX_W-1:0]] <= acc_reg;
        end
    end

    assign arg0     = arg_mem_reg[0];
    assign walk_arg = arg_mem_reg[walk_reg[IDX_W-1:0]];

    generate
        if (MAX_ARGS > 1)
        begin : g_arg1
            assign arg1 = arg_mem_reg[1];
        end
        else
        begin : g_no_arg1
            assign arg1 = '0;
        end
    endgenerate

    // Output register.
    logic              out_valid_reg, out_valid_next;
    aesp_pkg::result_t out_res_reg;
    logic [3:0]        out_fg_reg;
    logic [3:0]        out_bg_reg;
    logic              out_draw_reg;
    logic              out_load;

    assign out_load = (seq_reg == aesp_pkg::SQ_EMIT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_res_reg  <= res_reg;
            out_fg_reg   <= fg_reg;
            out_bg_reg   <= bg_reg;
            out_draw_reg <= draw_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.action;
    assign m_axis_tdata  = {7'd0, out_res_reg.repeat_byte, out_res_reg.repeat_count,
                            out_res_reg.erase_y1, out_res_reg.erase_x1,
                            out_res_reg.erase_y0, out_res_reg.erase_x0,
                            out_draw_reg, out_bg_reg, out_fg_reg,
                            out_res_reg.new_col, out_res_reg.new_row};

    // An argument minus one, clamped to 0..hi.
    function automatic logic [7:0] pos_from_arg(input logic [ARG_BITS-1:0] v,
                                                input logic [7:0] hi);
        logic [ARG_BITS-1:0] dec;
        dec = v - ARG_BITS'(1);
        if (v == '0)
        begin
            return 8'd0;
        end
        else if (dec > ARG_BITS'(hi))
        begin
            return hi;
        end
        return dec[7:0];
    endfunction

    // Datapath terms for the held byte.
    logic                is_digit;
    logic [ARG_BITS-1:0] acc_base;
    logic [ARG_BITS+3:0] acc_ext;
    logic [ARG_BITS-1:0] acc_sat;
    logic                have_args;
    logic [ARG_BITS-1:0] a_or0;
    logic [ARG_BITS-1:0] a_or1;
    logic [8:0]          row_inc;
    logic [8:0]          col_inc;
    logic [ARG_BITS:0]   erase_sum;
    logic [7:0]          erase_end;
    logic                walk_last;
    aesp_pkg::result_t   res_base;

    assign is_digit  = (byte_reg >= aesp_pkg::CH_ZERO) && (byte_reg <= aesp_pkg::CH_NINE);
    assign acc_base  = pending_reg ? acc_reg : '0;
    assign acc_ext   = {1'b0, acc_base, 3'b000} + {3'b000, acc_base, 1'b0}
                     + (ARG_BITS+4)'(byte_reg[3:0]);
    assign acc_sat   = (acc_ext > (ARG_BITS+4)'(ARG_SAT)) ? ARG_SAT : acc_ext[ARG_BITS-1:0];
    assign have_args = (arg_total_reg != '0);
    assign a_or0     = have_args ? arg0 : '0;
    assign a_or1     = have_args ? arg0 : ARG_BITS'(1);
    assign row_inc   = {1'b0, crow_reg} + 9'd1;
    assign col_inc   = {1'b0, ccol_reg} + 9'd1;
    assign erase_sum = (ARG_BITS+1)'(ccol_reg) + (ARG_BITS+1)'(a_or1);
    assign erase_end = (erase_sum > (ARG_BITS+1)'(cols_eff)) ? cols_eff : erase_sum[7:0];
    assign walk_last = ((walk_reg + CNT_W'(1)) == arg_total_reg);

    always_comb
    begin
        res_base              = '0;
        res_base.action       = aesp_pkg::ACT_REJECT;
        res_base.new_row      = crow_reg;
        res_base.new_col      = ccol_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= aesp_pkg::SQ_IDLE;
            phase_reg     <= aesp_pkg::PH_IDLE;
            arg_total_reg <= '0;
            pending_reg   <= 1'b0;
            walk_reg      <= '0;
            fg_reg        <= aesp_pkg::FG_RESET;
            bg_reg        <= aesp_pkg::BG_RESET;
            draw_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            phase_reg     <= phase_next;
            arg_total_reg <= arg_total_next;
            pending_reg   <= pending_next;
            walk_reg      <= walk_next;
            fg_reg        <= fg_next;
            bg_reg        <= bg_next;
            draw_reg      <= draw_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        res_reg <= res_next;
    end

    always_comb
    begin
        seq_next       = seq_reg;
        phase_next     = phase_reg;
        arg_total_next = arg_total_reg;
        pending_next   = pending_reg;
        acc_next       = acc_reg;
        walk_next      = walk_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        draw_next      = draw_reg;
        res_next       = res_reg;
        commit_en      = 1'b0;

        unique case (seq_reg)
            aesp_pkg::SQ_IDLE:
            begin
                if (in_accept)
                begin
                    seq_next = aesp_pkg::SQ_STEP;
                end
            end

            aesp_pkg::SQ_STEP:
            begin
                res_next = res_base;
                seq_next = aesp_pkg::SQ_IDLE;
                unique case (phase_reg)
                    aesp_pkg::PH_IDLE:
                    begin
                        if (byte_reg == aesp_pkg::CH_ESC)
                        begin
                            phase_next = aesp_pkg::PH_ESC;
                        end
                    end

                    aesp_pkg::PH_ESC:
                    begin
                        if (byte_reg == aesp_pkg::CH_LPAREN || byte_reg == aesp_pkg::CH_RPAREN)
                        begin
                            phase_next = aesp_pkg::PH_BDC;
                        end
                        else if (byte_reg == aesp_pkg::CH_LBRACKET)
                        begin
                            phase_next     = aesp_pkg::PH_CSI;
                            arg_total_next = '0;
                            pending_next   = 1'b0;
                        end
                        else
                        begin
                            phase_next = aesp_pkg::PH_IDLE;
                            seq_next   = aesp_pkg::SQ_EMIT;
                        end
                    end

                    aesp_pkg::PH_BDC:
                    begin
                        phase_next = aesp_pkg::PH_IDLE;
                        seq_next   = aesp_pkg::SQ_EMIT;
                        if (byte_reg == aesp_pkg::CH_ZERO)
                        begin
                            draw_next       = 1'b1;
                            res_next.action = aesp_pkg::ACT_DRAW_MODE;
                        end
                        else if (byte_reg == aesp_pkg::CH_DOWN)
                        begin
                            draw_next       = 1'b0;
                            res_next.action = aesp_pkg::ACT_DRAW_MODE;
                        end
                    end

                    aesp_pkg::PH_CSI:
                    begin
                        if (is_digit)
                        begin
                            acc_next     = acc_sat;
                            pending_next = 1'b1;
                        end
                        else if (byte_reg == aesp_pkg::CH_SEMI && !pending_reg)
                        begin
                            phase_next = aesp_pkg::PH_IDLE;
                            seq_next   = aesp_pkg::SQ_EMIT;
                        end
                        else if (pending_reg && arg_total_reg >= CNT_W'(MAX_ARGS))
                        begin
                            phase_next = aesp_pkg::PH_IDLE;
                            seq_next   = aesp_pkg::SQ_EMIT;
                        end
                        else
                        begin
                            if (pending_reg)
                            begin
                                commit_en      = 1'b1;
                                arg_total_next = arg_total_reg + CNT_W'(1);
                                pending_next   = 1'b0;
                            end
                            if (byte_reg != aesp_pkg::CH_SEMI && byte_reg != aesp_pkg::CH_QUEST)
                            begin
                                phase_next = aesp_pkg::PH_IDLE;
                                seq_next   = aesp_pkg::SQ_FINAL;
                            end
                        end
                    end
                endcase
            end

            aesp_pkg::SQ_FINAL:
            begin
                seq_next        = aesp_pkg::SQ_EMIT;
                res_next.action = aesp_pkg::ACT_UPDATE;
                unique case (byte_reg)
                    aesp_pkg::CH_UP:
                    begin
                        res_next.new_row = (crow_reg == 8'd0) ? 8'd0 : crow_reg - 8'd1;
                    end
                    aesp_pkg::CH_DOWN:
                    begin
                        res_next.new_row = (row_inc > {1'b0, max_row}) ? max_row : row_inc[7:0];
                    end
                    aesp_pkg::CH_RIGHT, aesp_pkg::CH_AT:
                    begin
                        res_next.new_col = (col_inc > {1'b0, max_col}) ? max_col : col_inc[7:0];
                    end
                    aesp_pkg::CH_LEFT:
                    begin
                        res_next.new_col = (ccol_reg == 8'd0) ? 8'd0 : ccol_reg - 8'd1;
                    end
                    aesp_pkg::CH_SGR:
                    begin
                        walk_next = '0;
                        if (!have_args)
                        begin
                            fg_next = def_fg_reg;
                            bg_next = def_bg_reg;
                        end
                        else
                        begin
                            seq_next = aesp_pkg::SQ_COLOR;
                        end
                    end
                    aesp_pkg::CH_RESET:
                    begin
                        fg_next = def_fg_reg;
                        bg_next = def_bg_reg;
                    end
                    aesp_pkg::CH_ERASE_DS:
                    begin
                        if (a_or0 == ARG_BITS'(0))
                        begin
                            res_next.action   = aesp_pkg::ACT_ERASE;
                            res_next.erase_y0 = crow_reg;
                            res_next.erase_x1 = cols_eff;
                            res_next.erase_y1 = rows_eff;
                        end
                        else if (a_or0 == ARG_BITS'(1))
                        begin
                            res_next.action   = aesp_pkg::ACT_ERASE;
                            res_next.erase_x1 = ccol_reg;
                            res_next.erase_y1 = crow_reg;
                        end
                        else if (a_or0 == ARG_BITS'(2))
                        begin
                            res_next.action   = aesp_pkg::ACT_ERASE;
                            res_next.erase_x1 = cols_eff;
                            res_next.erase_y1 = rows_eff;
                        end
                    end
                    aesp_pkg::CH_ERASE_LN:
                    begin
                        if (a_or0 == ARG_BITS'(0))
                        begin
                            res_next.action   = aesp_pkg::ACT_ERASE;
                            res_next.erase_x0 = ccol_reg;
                            res_next.erase_y0 = crow_reg;
                            res_next.erase_x1 = cols_eff;
                            res_next.erase_y1 = crow_reg;
                        end
                        else if (a_or0 == ARG_BITS'(1))
                        begin
                            res_next.action   = aesp_pkg::ACT_ERASE;
                            res_next.erase_y0 = crow_reg;
                            res_next.erase_x1 = ccol_reg;
                            res_next.erase_y1 = crow_reg;
                        end
                        else if (a_or0 == ARG_BITS'(2))
                        begin
                            res_next.action   = aesp_pkg::ACT_ERASE;
                            res_next.erase_y0 = crow_reg;
                            res_next.erase_x1 = cols_eff;
                            res_next.erase_y1 = crow_reg;
                        end
                    end
                    aesp_pkg::CH_ERASE_CH:
                    begin
                        res_next.action   = aesp_pkg::ACT_ERASE;
                        res_next.erase_x0 = ccol_reg;
                        res_next.erase_y0 = crow_reg;
                        res_next.erase_x1 = erase_end;
                        res_next.erase_y1 = crow_reg;
                    end
                    aesp_pkg::CH_POS:
                    begin
                        if (arg_total_reg < CNT_W'(2))
                        begin
                            res_next.new_row = 8'd0;
                            res_next.new_col = 8'd0;
                        end
                        else
                        begin
                            res_next.new_row = pos_from_arg(arg0, max_row);
                            res_next.new_col = pos_from_arg(arg1, max_col);
                        end
                    end
                    aesp_pkg::CH_ROW_ABS:
                    begin
                        res_next.new_row = pos_from_arg(a_or1, max_row);
                    end
                    aesp_pkg::CH_COL_ABS:
                    begin
                        res_next.new_col = pos_from_arg(a_or1, max_col);
                    end
                    aesp_pkg::CH_REPEAT:
                    begin
                        res_next.action = aesp_pkg::ACT_REPEAT;
                        if (prev_reg != 8'd0)
                        begin
                            res_next.repeat_count = (a_or1 > 32'hFFFF) ? 16'hFFFF : 16'(a_or1);
                            res_next.repeat_byte  = prev_reg;
                        end
                    end
                    default:
                    begin
                        res_next.action = aesp_pkg::ACT_REJECT;
                    end
                endcase
            end

            aesp_pkg::SQ_COLOR:
            begin
                if (walk_arg == ARG_BITS'(0))
                begin
                    fg_next = def_fg_reg;
                    bg_next = def_bg_reg;
                end
                else if (walk_arg >= aesp_pkg::SGR_FG_LO && walk_arg < aesp_pkg::SGR_BG_LO)
                begin
                    fg_next = 4'(walk_arg - ARG_BITS'(aesp_pkg::SGR_FG_LO));
                end
                else if (walk_arg >= aesp_pkg::SGR_BG_LO && walk_arg < aesp_pkg::SGR_BG_HI)
                begin
                    bg_next = 4'(walk_arg - ARG_BITS'(aesp_pkg::SGR_BG_LO));
                end
                walk_next = walk_reg + CNT_W'(1);
                if (walk_last)
                begin
                    seq_next = aesp_pkg::SQ_EMIT;
                end
            end

            aesp_pkg::SQ_EMIT:
            begin
                if (out_load)
                begin
                    seq_next = aesp_pkg::SQ_IDLE;
                end
            end

            default:
            begin
                seq_next = aesp_pkg::SQ_IDLE;
            end
        endcase
    end

    // The color walk only runs over arguments that were stored.
    assert property (@(posedge clk) disable iff (!rst_n)
        (seq_reg == aesp_pkg::SQ_COLOR) |-> (have_args && walk_reg < arg_total_reg))
    else $error("color walk outside the stored arguments");

    // The argument count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        arg_total_reg <= CNT_W'(MAX_ARGS))
    else $error("argument count beyond store depth");

    // A new result appears only when the sequencer hands one over.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !$past(m_axis_tvalid)) |-> $past(seq_reg == aesp_pkg::SQ_EMIT))
    else $error("result shown without a hand-over");

    // An accepted request is processed in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (seq_reg == aesp_pkg::SQ_STEP))
    else $error("accepted request not processed");

endmodule
